// File: rtl/core/apfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package apfe_pkg;

  // default build settings
  localparam int MAX_SAMPLES_DEF = 128;
  localparam int ADC_BITS_DEF    = 12;

  // fixed field widths
  localparam int SAMPLE_W  = 12;
  localparam int COUNT_W   = 5;
  localparam int THRESH_W  = 12;
  localparam int INDEX_W   = 7;
  localparam int BASE_W    = 16;
  localparam int PROD_W    = 17;
  localparam int HEIGHT_W  = 18;
  localparam int CHARGE_W  = 24;
  localparam int PEAK_W    = 17;
  localparam int PEAK_OUT_W = 16;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_BASELINE_COUNT  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_THRESHOLD = 8'd1;
  localparam logic [COUNT_W-1:0]  BASELINE_COUNT_RST  = 5'd6;
  localparam logic [THRESH_W-1:0] PULSE_THRESHOLD_RST = 12'd5;
  localparam logic [COUNT_W-1:0]  BASELINE_COUNT_MAX  = 5'd16;

  // stream data widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 88;

  // decoupling queue
  localparam int QUEUE_DEPTH = 2;

  // what a sample means to the back end
  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_BASE,
    KIND_MEAS
  } sample_kind_t;

  // one classified sample between front and back
  typedef struct packed {
    sample_kind_t              kind;
    logic                      last;
    logic [INDEX_W-1:0]        index;
    logic [PROD_W-1:0]         prod;
    logic [PROD_W-1:0]         thresh;
    logic [BASE_W-1:0]         base;
  } queue_entry_t;

  // one waveform summary
  typedef struct packed {
    logic [CHARGE_W-1:0]   tail_charge_scaled;
    logic [PEAK_OUT_W-1:0] peak_scaled;
    logic [CHARGE_W-1:0]   charge_scaled;
    logic [BASE_W-1:0]     baseline_sum;
    logic [INDEX_W-1:0]    first_index;
    logic                  pulse_found;
  } pulse_result_t;

endpackage

`default_nettype wire

// File: rtl/core/adc_pulse_feature_extractor_top.sv
// ADC pulse feature extractor.
// Slave stream: one raw ADC sample per transfer, tlast on the final sample of a
// waveform. The first baseline_count samples form the baseline sum; later
// samples are scaled by the count, baseline subtracted and checked against the
// threshold to find the first pulse sample, the charge, the peak and the
// negative tail charge.
// Master stream: one summary transfer per waveform, issued for the tlast sample.
// Config channel: index 0 baseline_count, index 1 pulse_threshold; cfg_ready is
// always high, write only between waveforms.
// Throughput: one sample per cycle while s_tready is high. The summary reaches
// the master side through the queue register, then the output register.
// A 2-entry queue sits between the classifying front end and the accumulating
// back end. While a summary waits in the output register on a stalled master
// side, the back end keeps taking samples; only the next tlast sample waits at
// the queue head, then the queue fills and s_tready drops.
// Reset (rst, synchronous): queue and output emptied, waveform state cleared,
// registers back to baseline_count 6, pulse_threshold 5.
`timescale 1ns / 1ps
`default_nettype none

module adc_pulse_feature_extractor_top #(
  parameter int MAX_SAMPLES = apfe_pkg::MAX_SAMPLES_DEF,
  parameter int ADC_BITS    = apfe_pkg::ADC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // adc_sample [11:0], zeros [15:12]
  input  wire logic [apfe_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // pulse_found [0], first_index [7:1], baseline_sum [23:8],
  // charge_scaled [47:24], peak_scaled [63:48], tail_charge_scaled [87:64]
  output logic [apfe_pkg::M_TDATA_W-1:0]           m_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [apfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [apfe_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [apfe_pkg::COUNT_W-1:0]   baseline_count;
  logic [apfe_pkg::THRESH_W-1:0]  pulse_threshold;

  apfe_pkg::queue_entry_t         front_entry;
  apfe_pkg::queue_entry_t         head;
  apfe_pkg::pulse_result_t        result;
  apfe_pkg::pulse_result_t        out_result;
  logic                           in_accept;
  logic                           queue_full;
  logic                           queue_avail;
  logic                           pop;
  logic                           result_load;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_count  <= apfe_pkg::BASELINE_COUNT_RST;
      pulse_threshold <= apfe_pkg::PULSE_THRESHOLD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        apfe_pkg::REG_BASELINE_COUNT:  baseline_count  <= cfg_data[apfe_pkg::COUNT_W-1:0];
        apfe_pkg::REG_PULSE_THRESHOLD: pulse_threshold <= cfg_data[apfe_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // input transfer
  assign s_axis_tready = !queue_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  apfe_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .ADC_BITS   (ADC_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_accept),
    .adc_sample     (s_axis_tdata[apfe_pkg::SAMPLE_W-1:0]),
    .last_sample    (s_axis_tlast),
    .baseline_count (baseline_count),
    .pulse_threshold(pulse_threshold),
    .entry          (front_entry)
  );

  apfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_entry(front_entry),
    .full      (queue_full),
    .pop       (pop),
    .head      (head),
    .not_empty (queue_avail)
  );

  // back end advances on plain samples, and on a last sample once the output
  // slot can take its summary
  assign pop = queue_avail && (!head.last || !m_axis_tvalid || m_axis_tready);

  apfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop        (pop),
    .head       (head),
    .result     (result),
    .result_load(result_load)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (result_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_result <= result;
    end
  end

  assign m_axis_tdata = out_result;

endmodule

`default_nettype wire

// File: rtl/core/apfe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module apfe_front #(
  parameter int MAX_SAMPLES = apfe_pkg::MAX_SAMPLES_DEF,
  parameter int ADC_BITS    = apfe_pkg::ADC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire logic [apfe_pkg::SAMPLE_W-1:0]    adc_sample,
  input  wire logic                             last_sample,
  input  wire logic [apfe_pkg::COUNT_W-1:0]     baseline_count,
  input  wire logic [apfe_pkg::THRESH_W-1:0]    pulse_threshold,
  output apfe_pkg::queue_entry_t                entry
);

  localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (IDX_W > apfe_pkg::COUNT_W) ? IDX_W : apfe_pkg::COUNT_W;
  localparam int SMP_W = (ADC_BITS < apfe_pkg::SAMPLE_W) ? ADC_BITS : apfe_pkg::SAMPLE_W;

  logic [IDX_W-1:0]                  sample_index;
  logic [apfe_pkg::BASE_W-1:0]       base_acc;
  logic [apfe_pkg::SAMPLE_W-1:0]     sample;
  logic [apfe_pkg::COUNT_W-1:0]      count_eff;
  logic                              in_range;
  logic                              is_base;
  logic [apfe_pkg::BASE_W:0]         base_sum;
  logic [apfe_pkg::BASE_W-1:0]       base_sat;

  // keep only the converter bits
  assign sample = apfe_pkg::SAMPLE_W'(adc_sample[SMP_W-1:0]);

  // baseline count clamped to 1..16
  always_comb begin
    if (baseline_count == '0) begin
      count_eff = apfe_pkg::COUNT_W'(1);
    end else if (baseline_count > apfe_pkg::BASELINE_COUNT_MAX) begin
      count_eff = apfe_pkg::BASELINE_COUNT_MAX;
    end else begin
      count_eff = baseline_count;
    end
  end

  // classify by position in the waveform
  assign in_range = CMP_W'(sample_index) < CMP_W'(MAX_SAMPLES);
  assign is_base  = CMP_W'(sample_index) < CMP_W'(count_eff);

  // saturating baseline sum
  assign base_sum = {1'b0, base_acc} + (apfe_pkg::BASE_W + 1)'(sample);
  assign base_sat = base_sum[apfe_pkg::BASE_W] ? '1 : base_sum[apfe_pkg::BASE_W-1:0];

  // entry handed to the back end
  always_comb begin
    entry.last   = last_sample;
    entry.index  = apfe_pkg::INDEX_W'(sample_index);
    entry.prod   = apfe_pkg::PROD_W'(sample) * apfe_pkg::PROD_W'(count_eff);
    entry.thresh = apfe_pkg::PROD_W'(pulse_threshold) * apfe_pkg::PROD_W'(count_eff);
    if (!in_range) begin
      entry.kind = apfe_pkg::KIND_SKIP;
      entry.base = base_acc;
    end else if (is_base) begin
      entry.kind = apfe_pkg::KIND_BASE;
      entry.base = base_sat;
    end else begin
      entry.kind = apfe_pkg::KIND_MEAS;
      entry.base = base_acc;
    end
  end

  // position and baseline, cleared at the end of each waveform
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      base_acc     <= '0;
    end else if (accept) begin
      if (last_sample) begin
        sample_index <= '0;
        base_acc     <= '0;
      end else if (in_range) begin
        sample_index <= sample_index + IDX_W'(1);
        if (is_base) begin
          base_acc <= base_sat;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/apfe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module apfe_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire apfe_pkg::queue_entry_t push_entry,
  output logic                        full,
  input  wire logic                   pop,
  output apfe_pkg::queue_entry_t      head,
  output logic                        not_empty
);

  localparam int DEPTH = apfe_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  apfe_pkg::queue_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = fill == CNT_W'(DEPTH);
  assign not_empty = fill != '0;
  assign head      = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/apfe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module apfe_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   pop,
  input  wire apfe_pkg::queue_entry_t head,
  output apfe_pkg::pulse_result_t     result,
  output logic                        result_load
);

  localparam int CW = apfe_pkg::CHARGE_W;
  localparam int PW = apfe_pkg::PEAK_W;
  localparam int HW = apfe_pkg::HEIGHT_W;

  logic [CW-1:0]                  charge_acc, charge_acc_next;
  logic [CW-1:0]                  tail_acc, tail_acc_next;
  logic [PW-1:0]                  peak_reg, peak_reg_next;
  logic                           tail_active, tail_active_next;
  logic                           found_flag, found_flag_next;
  logic [apfe_pkg::INDEX_W-1:0]   first_reg, first_reg_next;

  logic signed [HW-1:0]           height;
  logic                           is_pulse;
  logic                           is_neg;
  logic [PW-1:0]                  h_pos;
  logic [PW-1:0]                  h_mag;
  logic [CW:0]                    charge_sum;
  logic [CW:0]                    tail_sum;

  // scaled height and its classification
  assign height   = $signed({1'b0, head.prod}) - $signed(HW'(head.base));
  assign is_pulse = height > $signed({1'b0, head.thresh});
  assign is_neg   = height[HW-1];
  assign h_pos    = height[PW-1:0];
  assign h_mag    = PW'(-height);

  assign charge_sum = {1'b0, charge_acc} + (CW + 1)'(h_pos);
  assign tail_sum   = {1'b0, tail_acc} + (CW + 1)'(h_mag);

  // feature update for one sample
  always_comb begin
    charge_acc_next  = charge_acc;
    tail_acc_next    = tail_acc;
    peak_reg_next    = peak_reg;
    tail_active_next = tail_active;
    found_flag_next  = found_flag;
    first_reg_next   = first_reg;
    if (pop && head.kind == apfe_pkg::KIND_MEAS) begin
      if (is_pulse) begin
        if (!tail_active) begin
          if (!found_flag) begin
            found_flag_next = 1'b1;
            first_reg_next  = head.index;
          end
          charge_acc_next = charge_sum[CW] ? '1 : charge_sum[CW-1:0];
          if (h_pos > peak_reg) begin
            peak_reg_next = h_pos;
          end
        end
      end else if (is_neg) begin
        if (found_flag) begin
          tail_active_next = 1'b1;
          tail_acc_next    = tail_sum[CW] ? '1 : tail_sum[CW-1:0];
        end
      end
    end
  end

  // summary of the waveform on its last sample
  assign result_load = pop && head.last;

  always_comb begin
    result.pulse_found        = found_flag_next;
    result.first_index        = first_reg_next;
    result.baseline_sum       = head.base;
    result.charge_scaled      = charge_acc_next;
    result.peak_scaled        = peak_reg_next[PW-1] ? '1 : peak_reg_next[PW-2:0];
    result.tail_charge_scaled = tail_acc_next;
  end

  // feature state, cleared after each waveform
  always_ff @(posedge clk) begin
    if (rst || result_load) begin
      charge_acc  <= '0;
      tail_acc    <= '0;
      peak_reg    <= '0;
      tail_active <= 1'b0;
      found_flag  <= 1'b0;
      first_reg   <= '0;
    end else begin
      charge_acc  <= charge_acc_next;
      tail_acc    <= tail_acc_next;
      peak_reg    <= peak_reg_next;
      tail_active <= tail_active_next;
      found_flag  <= found_flag_next;
      first_reg   <= first_reg_next;
    end
  end

endmodule

`default_nettype wire

// File: bench/pulse_summary_checker.sv
`timescale 1ns / 1ps

// watches the sample, config and summary channels of the pulse feature
// extractor, keeps its own copy of the waveform state and checks every summary
module pulse_summary_checker
  import apfe_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic [S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                    s_axis_tlast,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [M_TDATA_W-1:0]    m_axis_tdata,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output int                      failures,
  output int                      pending,
  output int                      summaries_checked
);

  localparam int WAVE_LIMIT = MAX_SAMPLES_DEF;
  localparam int SAT24 = 24'hFFFFFF;
  localparam int SAT16 = 16'hFFFF;

  // shadow of the configuration registers
  logic [COUNT_W-1:0]  shadow_count;
  logic [THRESH_W-1:0] shadow_thresh;

  // running state of the waveform in progress
  int wave_pos;
  int base_sum;
  int pulse_charge;
  int pulse_peak;
  int undershoot;
  bit in_tail;
  bit seen_pulse;
  int first_pos;

  // summaries waiting for their transfer
  pulse_result_t summary_q[$];

  function automatic int add_sat24(input int acc, input int v);
    return (acc + v > SAT24) ? SAT24 : acc + v;
  endfunction

  task automatic clear_wave();
    wave_pos     = 0;
    base_sum     = 0;
    pulse_charge = 0;
    pulse_peak   = 0;
    undershoot   = 0;
    in_tail      = 1'b0;
    seen_pulse   = 1'b0;
    first_pos    = 0;
  endtask

  // advance the waveform state by one sample, queue a summary on the last one
  task automatic fold_sample(input logic [SAMPLE_W-1:0] raw, input logic is_last);
    int n;
    int height;
    int floor_lvl;
    pulse_result_t summary;
    n = (shadow_count == 0) ? 1 : ((shadow_count > 16) ? 16 : int'(shadow_count));
    if (wave_pos < WAVE_LIMIT) begin
      if (wave_pos < n) begin
        base_sum = base_sum + int'(raw);
        if (base_sum > SAT16) base_sum = SAT16;
      end else begin
        height    = int'(raw) * n - base_sum;
        floor_lvl = int'(shadow_thresh) * n;
        if (height > floor_lvl) begin
          // pulse samples only count until the tail has started
          if (!in_tail) begin
            if (!seen_pulse) begin
              seen_pulse = 1'b1;
              first_pos  = wave_pos;
            end
            pulse_charge = add_sat24(pulse_charge, height);
            if (height > pulse_peak) pulse_peak = height;
          end
        end else if (height < 0) begin
          if (seen_pulse) in_tail = 1'b1;
          if (in_tail) undershoot = add_sat24(undershoot, -height);
        end
      end
      wave_pos++;
    end
    if (is_last) begin
      summary.pulse_found        = seen_pulse;
      summary.first_index        = seen_pulse ? INDEX_W'(first_pos) : '0;
      summary.baseline_sum       = BASE_W'(base_sum);
      summary.charge_scaled      = CHARGE_W'(pulse_charge);
      summary.peak_scaled        = (pulse_peak > SAT16) ? '1 : PEAK_OUT_W'(pulse_peak);
      summary.tail_charge_scaled = CHARGE_W'(undershoot);
      summary_q.insert(summary_q.size(), summary);
      clear_wave();
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  initial begin
    failures          = 0;
    pending           = 0;
    summaries_checked = 0;
    shadow_count      = BASELINE_COUNT_RST;
    shadow_thresh     = PULSE_THRESHOLD_RST;
    clear_wave();
  end

  // all channel activity is taken at the rising edge
  always @(posedge clk) begin
    pulse_result_t got;
    pulse_result_t want;
    if (rst) begin
      shadow_count  = BASELINE_COUNT_RST;
      shadow_thresh = PULSE_THRESHOLD_RST;
      clear_wave();
      summary_q.delete();
    end else begin
      // summary transfer
      if (m_axis_tvalid && m_axis_tready) begin
        got = pulse_result_t'(m_axis_tdata);
        if (summary_q.size() == 0) begin
          failures++;
          $display("%0t: summary with none expected, expected nothing, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want = summary_q.pop_front();
          summaries_checked++;
          check_field("pulse_found", want.pulse_found, got.pulse_found);
          check_field("first_index", want.first_index, got.first_index);
          check_field("baseline_sum", want.baseline_sum, got.baseline_sum);
          check_field("charge_scaled", want.charge_scaled, got.charge_scaled);
          check_field("peak_scaled", want.peak_scaled, got.peak_scaled);
          check_field("tail_charge_scaled", want.tail_charge_scaled,
                      got.tail_charge_scaled);
        end
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASELINE_COUNT: begin
            shadow_count = cfg_data[COUNT_W-1:0];
          end
          REG_PULSE_THRESHOLD: begin
            shadow_thresh = cfg_data[THRESH_W-1:0];
          end
          default: begin
          end
        endcase
      end
      // sample transfer
      if (s_axis_tvalid && s_axis_tready)
        fold_sample(s_axis_tdata[SAMPLE_W-1:0], s_axis_tlast);
    end
    pending = summary_q.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import apfe_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd2;
  localparam int HOLD_CYCLES = 120;
  localparam int SEGMENT_SAMPLES = 56;

  logic                   clk;
  logic                   rst;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int failures;
  int pending;
  int summaries_checked;

  // stimulus bookkeeping
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int holds_served;
  int cur_count;
  int samples_sent;
  int waveforms_sent;
  int overlong_sent;

  adc_pulse_feature_extractor_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pulse_summary_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tlast      (s_axis_tlast),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .failures          (failures),
    .pending           (pending),
    .summaries_checked (summaries_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    #4_000_000;
    $display("timeout with %0d summaries outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

  // summary receiver: random stalls, plus long hold-offs on request
  initial begin
    m_axis_tready = 1'b0;
    holds_served  = 0;
    forever begin
      @(negedge clk);
      if (holds_served < hold_requests) begin
        holds_served++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] clip(input int v);
    return (v < 0) ? '0 : ((v > 4095) ? 12'hFFF : SAMPLE_W'(v));
  endfunction

  // one sample transfer with random gaps in front of it
  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic is_last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, smp};
    s_axis_tlast  <= is_last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    samples_sent++;
    if (is_last) waveforms_sent++;
  endtask

  // register write once the block has drained
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_BASELINE_COUNT)
      cur_count = (val[COUNT_W-1:0] == 0) ? 1 :
                  ((val[COUNT_W-1:0] > 16) ? 16 : int'(val[COUNT_W-1:0]));
  endtask

  // baseline, a pulse with rise and decay, an undershoot, then back to baseline
  task automatic play_shaped(input int len);
    int base_lvl;
    int amp;
    int start;
    int rise;
    int fall;
    int dip;
    int dip_len;
    int jitter;
    int rel;
    int v;
    base_lvl = $urandom_range(300, 3700);
    amp      = $urandom_range(1, 4095 - base_lvl);
    dip      = $urandom_range(0, base_lvl / 3);
    jitter   = $urandom_range(0, 4);
    rise     = $urandom_range(1, 3);
    fall     = $urandom_range(1, 6);
    dip_len  = $urandom_range(1, 8);
    start    = cur_count + $urandom_range(0, (len > cur_count + 1) ? len - cur_count - 1 : 0);
    for (int k = 0; k < len; k++) begin
      rel = k - start;
      if (rel < 0)
        v = base_lvl;
      else if (rel < rise)
        v = base_lvl + amp * (rel + 1) / rise;
      else if (rel < rise + fall)
        v = base_lvl + amp - amp * (rel - rise + 1) / fall;
      else if (rel < rise + fall + dip_len)
        v = base_lvl - dip;
      else
        v = base_lvl;
      v = v + int'($urandom_range(0, 2 * jitter)) - jitter;
      push_sample(clip(v), k == len - 1);
    end
  endtask

  task automatic play_noise(input int len);
    for (int k = 0; k < len; k++)
      push_sample(SAMPLE_W'($urandom_range(4095)), k == len - 1);
  endtask

  // one stretch of random waveforms under the current settings
  task automatic play_segment();
    int seg_start;
    int pick;
    int len;
    seg_start = samples_sent;
    while (samples_sent - seg_start < SEGMENT_SAMPLES) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        play_shaped(cur_count + $urandom_range(3, 30));
      end else if (pick < 85) begin
        play_noise($urandom_range(1, 24));
      end else if (pick < 93) begin
        // ends inside the baseline
        len = $urandom_range(1, cur_count);
        play_shaped(len);
      end else if (pick < 96 && overlong_sent < 4) begin
        overlong_sent++;
        play_shaped($urandom_range(MAX_SAMPLES_DEF + 1, MAX_SAMPLES_DEF + 12));
      end else begin
        play_shaped(cur_count + $urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    s_axis_tvalid  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_requests  = 0;
    cur_count      = int'(BASELINE_COUNT_RST);
    samples_sent   = 0;
    waveforms_sent = 0;
    overlong_sent  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: default settings, waveform ending on its first sample
    push_sample(12'd0, 1'b1);

    // count of zero acts as one, zero threshold: pulse, tail, ignored late pulse
    write_reg(REG_BASELINE_COUNT, 12'd0);
    write_reg(REG_PULSE_THRESHOLD, 12'd0);
    push_sample(12'd2048, 1'b0);
    push_sample(12'hFFF, 1'b0);
    push_sample(12'd0, 1'b0);
    push_sample(12'hFFF, 1'b1);

    // count above sixteen acts as sixteen; largest possible peak
    write_reg(REG_BASELINE_COUNT, 12'hFFF);
    for (int k = 0; k < 16; k++) push_sample(12'd0, 1'b0);
    push_sample(12'hFFF, 1'b1);

    // write to an unmapped index is ignored, count written with upper bits set
    write_reg(REG_UNMAPPED, 12'hABC);
    write_reg(REG_BASELINE_COUNT, 12'h0E1);

    // threshold change in the middle of a waveform
    push_sample(12'd100, 1'b0);
    push_sample(12'd50, 1'b0);
    write_reg(REG_PULSE_THRESHOLD, 12'hFFF);
    push_sample(12'hFFF, 1'b0);
    push_sample(12'd0, 1'b1);

    // random part in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        case (phase * 4 + seg)
          0: begin
            write_reg(REG_BASELINE_COUNT, 12'd16);
            write_reg(REG_PULSE_THRESHOLD, 12'd0);
          end
          1: begin
            write_reg(REG_BASELINE_COUNT, 12'd1);
            write_reg(REG_PULSE_THRESHOLD, 12'hFFF);
          end
          4: begin
            write_reg(REG_BASELINE_COUNT, 12'd16);
            write_reg(REG_PULSE_THRESHOLD, 12'hFFF);
          end
          5: begin
            write_reg(REG_BASELINE_COUNT, 12'd1);
            write_reg(REG_PULSE_THRESHOLD, 12'd0);
          end
          default: begin
            write_reg(REG_BASELINE_COUNT, CFG_DATA_W'($urandom_range(1, 16)));
            write_reg(REG_PULSE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 300)));
          end
        endcase
        // long receiver hold-off while single-sample waveforms keep coming
        if (phase == 2 && seg == 0) begin
          hold_requests++;
          for (int k = 0; k < 16; k++)
            push_sample(SAMPLE_W'($urandom_range(4095)), 1'b1);
        end
        play_segment();
      end
    end

    // drain
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);

    $display("ran %0d waveforms (%0d samples, %0d overlong) through several settings",
             waveforms_sent, samples_sent, overlong_sent);
    $display("%0d summaries compared, %0d mismatches", summaries_checked, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/apfe_pkg.sv
rtl/core/apfe_front.sv
rtl/core/apfe_queue.sv
rtl/core/apfe_back.sv
rtl/core/adc_pulse_feature_extractor_top.sv
bench/pulse_summary_checker.sv
bench/testbench.sv
